@@ rtl/b64pcm_pkg.sv @@
// shared types, constants and the character decode function for the base64 pcm16 decoder
// no dependencies; imported by b64pcm_core, b64pcm_outreg, the top level and the testbench
package b64pcm_pkg;

    // character codes with a meaning of their own
    localparam logic [7:0] CH_EQUALS  = 8'h3D;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_DIGIT_0 = 8'h30;
    localparam logic [7:0] CH_DIGIT_9 = 8'h39;

    localparam int SAMPLE_W = 16;
    localparam int REPORT_W = 16;

    typedef struct packed {
        logic       valid;
        logic [5:0] value;
    } b64pcm_sextet_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                has_sample;
        logic                end_of_buffer;
        logic [REPORT_W-1:0] samples_in_buffer;
        logic                buffer_empty;
    } b64pcm_result_t;

    function automatic logic is_stop_char(input logic [7:0] ch);
        return (ch == CH_EQUALS) || (ch == CH_CR) || (ch == CH_LF) || (ch == CH_SPACE);
    endfunction

    // six-bit value of an alphabet character
    function automatic b64pcm_sextet_t sextet_of(input logic [7:0] ch);
        b64pcm_sextet_t s;
        logic [7:0]     d;
        s = '0;
        d = '0;
        if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z)
        begin
            d = ch - CH_UPPER_A;
            s.valid = 1'b1;
            s.value = d[5:0];
        end
        else if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z)
        begin
            d = ch - CH_LOWER_A + 8'd26;
            s.valid = 1'b1;
            s.value = d[5:0];
        end
        else if (ch >= CH_DIGIT_0 && ch <= CH_DIGIT_9)
        begin
            d = ch - CH_DIGIT_0 + 8'd52;
            s.valid = 1'b1;
            s.value = d[5:0];
        end
        else if (ch == CH_PLUS)
        begin
            s.valid = 1'b1;
            s.value = 6'd62;
        end
        else if (ch == CH_SLASH)
        begin
            s.valid = 1'b1;
            s.value = 6'd63;
        end
        return s;
    endfunction

endpackage

@@ rtl/b64pcm_core.sv @@
// per-buffer decode state and the single-pass character update
// depends on b64pcm_pkg
module b64pcm_core
    import b64pcm_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           accept,
    input  logic [7:0]     char_code,
    input  logic           last_char,
    output logic           res_valid,
    output b64pcm_result_t result
);

    logic [5:0]             residue_bits_reg, residue_bits_next;
    logic [2:0]             residue_count_reg, residue_count_next;
    logic [7:0]             low_byte_reg, low_byte_next;
    logic                   low_byte_held_reg, low_byte_held_next;
    logic                   decode_stopped_reg, decode_stopped_next;
    logic [COUNT_WIDTH-1:0] sample_total_reg, sample_total_next;

    b64pcm_sextet_t         sx;
    logic [11:0]            acc;
    logic [2:0]             shamt;
    logic [11:0]            acc_shifted;
    logic [11:0]            keep_mask;
    logic [7:0]             byte_out;
    logic                   formed;
    logic [SAMPLE_W-1:0]    word;
    logic [REPORT_W-1:0]    report;

    assign sx          = sextet_of(char_code);
    assign acc         = {residue_bits_reg, sx.value};
    assign shamt       = residue_count_reg - 3'd2;
    assign acc_shifted = acc >> shamt;
    assign byte_out    = acc_shifted[7:0];
    assign keep_mask   = (12'd1 << shamt) - 12'd1;

    always_comb
    begin
        residue_bits_next   = residue_bits_reg;
        residue_count_next  = residue_count_reg;
        low_byte_next       = low_byte_reg;
        low_byte_held_next  = low_byte_held_reg;
        decode_stopped_next = decode_stopped_reg;
        sample_total_next   = sample_total_reg;
        formed              = 1'b0;
        word                = '0;
        if (!decode_stopped_reg)
        begin
            if (is_stop_char(char_code))
            begin
                decode_stopped_next = 1'b1;
            end
            else if (sx.valid)
            begin
                if (residue_count_reg >= 3'd2)
                begin
                    residue_bits_next  = 6'(acc & keep_mask);
                    residue_count_next = shamt;
                    if (low_byte_held_reg)
                    begin
                        word               = {byte_out, low_byte_reg};
                        low_byte_held_next = 1'b0;
                        formed             = 1'b1;
                        if (sample_total_reg != '1)
                        begin
                            sample_total_next = sample_total_reg + COUNT_WIDTH'(1);
                        end
                    end
                    else
                    begin
                        low_byte_next      = byte_out;
                        low_byte_held_next = 1'b1;
                    end
                end
                else
                begin
                    residue_bits_next  = sx.value;
                    residue_count_next = residue_count_reg + 3'd6;
                end
            end
        end
    end

    // count as reported, capped at the field maximum
    generate
        if (COUNT_WIDTH > REPORT_W)
        begin : g_cap
            assign report = (|sample_total_next[COUNT_WIDTH-1:REPORT_W])
                          ? '1 : sample_total_next[REPORT_W-1:0];
        end
        else if (COUNT_WIDTH == REPORT_W)
        begin : g_same
            assign report = sample_total_next;
        end
        else
        begin : g_ext
            assign report = {{(REPORT_W-COUNT_WIDTH){1'b0}}, sample_total_next};
        end
    endgenerate

    assign res_valid                = formed || last_char;
    assign result.sample            = word;
    assign result.has_sample        = formed;
    assign result.end_of_buffer     = last_char;
    assign result.samples_in_buffer = report;
    assign result.buffer_empty      = last_char && (sample_total_next == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            residue_bits_reg   <= '0;
            residue_count_reg  <= '0;
            low_byte_reg       <= '0;
            low_byte_held_reg  <= 1'b0;
            decode_stopped_reg <= 1'b0;
            sample_total_reg   <= '0;
        end
        else if (accept)
        begin
            if (last_char)
            begin
                // buffer closes: drop residue and any odd trailing byte
                residue_bits_reg   <= '0;
                residue_count_reg  <= '0;
                low_byte_reg       <= '0;
                low_byte_held_reg  <= 1'b0;
                decode_stopped_reg <= 1'b0;
                sample_total_reg   <= '0;
            end
            else
            begin
                residue_bits_reg   <= residue_bits_next;
                residue_count_reg  <= residue_count_next;
                low_byte_reg       <= low_byte_next;
                low_byte_held_reg  <= low_byte_held_next;
                decode_stopped_reg <= decode_stopped_next;
                sample_total_reg   <= sample_total_next;
            end
        end
    end

endmodule

@@ rtl/b64pcm_outreg.sv @@
// result register between the decode logic and the output stream
// depends on b64pcm_pkg
module b64pcm_outreg
    import b64pcm_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           load,
    input  b64pcm_result_t load_data,
    input  logic           out_ready,
    output logic           out_valid,
    output b64pcm_result_t out_data,
    output logic           in_ready
);

    logic           valid_reg, valid_next;
    b64pcm_result_t data_reg;

    // free slot, or the held result leaves this cycle
    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

@@ rtl/base64_pcm16_sample_decoder_unit.sv @@
// top level of the base64 to pcm16 sample decoder: stream ports, decode core, result register
// depends on b64pcm_pkg, b64pcm_core and b64pcm_outreg
//
// The block takes one base64 character per transaction on the slave side and
// gives at most one result per character on the master side, one character
// per clock when not stalled. The character is decoded and the buffer state
// updated in the cycle it is accepted; the result sits in a single output
// register, so a result appears on the master side in the next cycle, and
// s_tready stays high whenever that register is empty or being drained.
// Every two decoded bytes form one little-endian signed 16-bit sample in
// Q0.15. Characters outside the alphabet are skipped; '=', CR, LF or space
// stop decoding until the end of the buffer. The character carrying s_tlast
// closes the buffer: its result reports the sample count (saturating) and
// whether the buffer was empty, and the decode state then clears, dropping
// any odd trailing byte. Characters that neither complete a sample nor close
// a buffer produce no transaction.
module base64_pcm16_sample_decoder_unit
    import b64pcm_pkg::*;
#(
    parameter int COUNT_WIDTH = 16   // width of the internal sample counter, 8 to 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    // character stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    input  logic        s_tlast,   // last_char
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [15:0] sample, [31:16] samples_in_buffer
    output logic        m_tlast,   // end_of_buffer
    output logic [1:0]  m_tuser    // [0] has_sample, [1] buffer_empty
);

    logic           accept;
    logic           res_valid;
    b64pcm_result_t core_result;
    b64pcm_result_t out_result;

    // a character transaction completes
    assign accept = s_tvalid && s_tready;

    b64pcm_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .char_code (s_tdata),
        .last_char (s_tlast),
        .res_valid (res_valid),
        .result    (core_result)
    );

    // only characters that form a sample or close a buffer give a result
    b64pcm_outreg u_outreg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept && res_valid),
        .load_data (core_result),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_data  (out_result),
        .in_ready  (s_tready)
    );

    // pack the result fields, lowest field in the lowest bits
    assign m_tdata = {out_result.samples_in_buffer, out_result.sample};
    assign m_tlast = out_result.end_of_buffer;
    assign m_tuser = {out_result.buffer_empty, out_result.has_sample};

endmodule

@@ rtl/b64pcm_checker.sv @@
// port-level checks for the base64 pcm16 decoder and their attachment to the top level
// depends on base64_pcm16_sample_decoder_unit
module b64pcm_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tlast,
    input logic [1:0]  m_tuser
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
                                  && $stable(m_tuser))
        else $error("result changed while stalled");

    // an empty output register never blocks the input
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output register");

    // every result carries a sample or closes a buffer
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tuser[0] || m_tlast)
        else $error("result with neither sample nor end of buffer");

    // sample field is zero without a sample, empty flag only at end of buffer
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser[0] || m_tdata[15:0] == 16'd0) && (m_tlast || !m_tuser[1]))
        else $error("stray sample bits or empty flag");

    // an empty buffer reports a zero count and no sample
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> m_tdata[31:16] == 16'd0 && !m_tuser[0])
        else $error("empty buffer with samples");

endmodule

bind base64_pcm16_sample_decoder_unit b64pcm_checker u_b64pcm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

@@ tb/tb.sv @@
// self-checking testbench for base64_pcm16_sample_decoder_unit: directed table, random
// buffers and one long full-rate buffer, each result checked against a predictor or typed row
// depends on b64pcm_pkg for the result type and character codes
`timescale 1ns / 1ps

module tb;
    import b64pcm_pkg::*;

    localparam int RANDOM_CHARS  = 1500;
    localparam int HOLD_CYCLES   = 300;    // long receiver hold-off, fills the result register
    localparam int QUIET_LIMIT   = 2000;   // cycles with no transaction before giving up
    localparam int DRAIN_CYCLES  = 10;
    localparam int LONG_QUADS    = 40;     // 120 bytes sent back to back in one buffer

    localparam logic [3:0][7:0] STOP_SET = {CH_SPACE, CH_LF, CH_CR, CH_EQUALS};

    // end-of-buffer results that can be written down without any decoding
    localparam b64pcm_result_t EMPTY_END = '{sample: 16'd0, has_sample: 1'b0,
        end_of_buffer: 1'b1, samples_in_buffer: 16'd0, buffer_empty: 1'b1};
    localparam b64pcm_result_t ONE_END = '{sample: 16'd0, has_sample: 1'b0,
        end_of_buffer: 1'b1, samples_in_buffer: 16'd1, buffer_empty: 1'b0};
    localparam b64pcm_result_t TWO_END = '{sample: 16'd0, has_sample: 1'b0,
        end_of_buffer: 1'b1, samples_in_buffer: 16'd2, buffer_empty: 1'b0};

    typedef struct packed {
        logic [7:0]     ch;
        logic           last;
        logic           typed;   // expected result given in the row itself
        b64pcm_result_t want;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;    // [7:0] char_code
    logic        s_tlast;    // last_char
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;    // [15:0] sample, [31:16] samples_in_buffer
    logic        m_tlast;    // end_of_buffer
    logic [1:0]  m_tuser;    // [0] has_sample, [1] buffer_empty

    // decoder state mirrored by the predictor
    logic [5:0]  carry_bits;
    logic [2:0]  carry_count;
    logic [7:0]  held_byte;
    logic        byte_waiting;
    logic        text_stopped;
    logic [15:0] buffer_samples;

    b64pcm_result_t pending_results[$];
    int             mismatches;
    int             chars_accepted;
    bit             no_gaps;        // sender offers back to back
    bit             always_ready;   // receiver never stalls
    bit             hold_request;   // ask the receiver for one long hold-off

    stim_row_t      directed_rows[25];

    base64_pcm16_sample_decoder_unit u_top
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always #6 clk = ~clk;

    // six-bit value of an alphabet character, valid clear for anything else
    function automatic b64pcm_sextet_t alphabet_value(input logic [7:0] ch);
        b64pcm_sextet_t s;
        s = '0;
        if (ch >= "A" && ch <= "Z")
        begin
            s.valid = 1'b1;
            s.value = 6'(ch - 8'd65);
        end
        else if (ch >= "a" && ch <= "z")
        begin
            s.valid = 1'b1;
            s.value = 6'(ch - 8'd97 + 8'd26);
        end
        else if (ch >= "0" && ch <= "9")
        begin
            s.valid = 1'b1;
            s.value = 6'(ch - 8'd48 + 8'd52);
        end
        else if (ch == CH_PLUS)
        begin
            s.valid = 1'b1;
            s.value = 6'd62;
        end
        else if (ch == CH_SLASH)
        begin
            s.valid = 1'b1;
            s.value = 6'd63;
        end
        return s;
    endfunction

    function automatic logic [7:0] alphabet_char(input logic [5:0] v);
        if (v < 6'd26)
            return 8'd65 + 8'(v);
        else if (v < 6'd52)
            return 8'd97 + 8'(v - 6'd26);
        else if (v < 6'd62)
            return 8'd48 + 8'(v - 6'd52);
        else if (v == 6'd62)
            return CH_PLUS;
        return CH_SLASH;
    endfunction

    // predictor: advance the mirrored state by one accepted character and queue
    // the result it causes, if any
    function automatic void decode_char(input logic [7:0] ch, input logic last,
                                        input logic typed, input b64pcm_result_t want);
        b64pcm_sextet_t s;
        b64pcm_result_t r;
        logic [11:0]    acc;
        logic [7:0]     octet;
        int unsigned    n;
        logic           formed;
        logic [15:0]    word;
        formed = 1'b0;
        word   = '0;
        s      = alphabet_value(ch);
        if (!text_stopped)
        begin
            if (ch == CH_EQUALS || ch == CH_CR || ch == CH_LF || ch == CH_SPACE)
                text_stopped = 1'b1;
            else if (s.valid)
            begin
                acc = {carry_bits, s.value};
                n   = carry_count + 6;
                if (n >= 8)
                begin
                    n           = n - 8;
                    octet       = 8'(acc >> n);
                    carry_bits  = 6'(acc & ((12'd1 << n) - 12'd1));
                    carry_count = 3'(n);
                    if (byte_waiting)
                    begin
                        word         = {octet, held_byte};
                        byte_waiting = 1'b0;
                        formed       = 1'b1;
                        if (buffer_samples != 16'hFFFF)
                            buffer_samples = buffer_samples + 16'd1;
                    end
                    else
                    begin
                        held_byte    = octet;
                        byte_waiting = 1'b1;
                    end
                end
                else
                begin
                    carry_bits  = acc[5:0];
                    carry_count = 3'(n);
                end
            end
        end
        if (formed || last)
        begin
            r.sample            = formed ? word : 16'd0;
            r.has_sample        = formed;
            r.end_of_buffer     = last;
            r.samples_in_buffer = buffer_samples;
            r.buffer_empty      = last && (buffer_samples == 16'd0);
            pending_results     = {pending_results, (typed ? want : r)};
        end
        if (last)
        begin
            carry_bits     = '0;
            carry_count    = '0;
            held_byte      = '0;
            byte_waiting   = 1'b0;
            text_stopped   = 1'b0;
            buffer_samples = '0;
        end
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        $display("[%0t] %s: got %0h, expected %0h", $realtime, what, got, want);
    endtask

    // offer one character and hold it until the transaction completes
    task automatic send_char(input logic [7:0] ch, input logic last,
                             input logic typed, input b64pcm_result_t want);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
        decode_char(ch, last, typed, want);
        chars_accepted++;
    endtask

    // sender stops and waits for every outstanding result
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    // one buffer: mostly well-formed text, sometimes noise or text cut by a stop
    task automatic send_random_buffer();
        int         kind;
        int         len;
        int         cut;
        int         pad;
        logic [7:0] junk;
        kind = $urandom_range(0, 9);
        if (kind == 0)
        begin
            // raw bytes of any value
            len = $urandom_range(1, 8);
            for (int i = 0; i < len; i++)
                send_char(8'($urandom_range(0, 255)), i == len - 1, 1'b0, '0);
        end
        else
        begin
            len = (kind == 2) ? 1 : $urandom_range(1, 40);
            cut = (kind == 1) ? $urandom_range(0, len - 1) : -1;
            pad = (kind >= 8) ? $urandom_range(1, 2) : 0;
            for (int i = 0; i < len; i++)
            begin
                if (i == cut)
                    send_char(STOP_SET[$urandom_range(0, 3)], 1'b0, 1'b0, '0);
                if ($urandom_range(0, 19) == 0)
                begin
                    // a character outside the alphabet that is no stop either
                    do
                        junk = 8'($urandom_range(0, 255));
                    while (alphabet_value(junk).valid || junk == CH_EQUALS || junk == CH_CR
                           || junk == CH_LF || junk == CH_SPACE);
                    send_char(junk, 1'b0, 1'b0, '0);
                end
                send_char(alphabet_char(6'($urandom_range(0, 63))),
                          (pad == 0) && (i == len - 1), 1'b0, '0);
            end
            for (int p = 0; p < pad; p++)
                send_char(CH_EQUALS, p == pad - 1, 1'b0, '0);
        end
    endtask

    // result checker: every result transaction against the oldest expectation
    always @(posedge clk)
    begin : result_check
        b64pcm_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result with nothing expected", m_tdata, 0);
            else
            begin
                want = pending_results.pop_front();
                if (m_tdata[15:0] !== want.sample)
                    report_mismatch("sample", m_tdata[15:0], want.sample);
                if (m_tuser[0] !== want.has_sample)
                    report_mismatch("has_sample", m_tuser[0], want.has_sample);
                if (m_tlast !== want.end_of_buffer)
                    report_mismatch("end_of_buffer", m_tlast, want.end_of_buffer);
                if (m_tdata[31:16] !== want.samples_in_buffer)
                    report_mismatch("samples_in_buffer", m_tdata[31:16],
                                    want.samples_in_buffer);
                if (m_tuser[1] !== want.buffer_empty)
                    report_mismatch("buffer_empty", m_tuser[1], want.buffer_empty);
            end
        end
    end

    // receiver: random stall before each result transaction, one long hold-off on request
    initial
    begin : receiver
        int stall;
        m_tready <= 1'b0;
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            stall = always_ready ? 0 : $urandom_range(0, 5);
            if (hold_request)
            begin
                hold_request = 1'b0;
                stall = HOLD_CYCLES;
            end
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
        end
    end

    // watchdog: too long without any transaction on either side
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Mismatches found");
        $finish;
    end

    // sender and run control
    initial
    begin : stimulus
        int  start_count;
        bit  paused;
        rst_n          <= 1'b0;
        s_tvalid       <= 1'b0;
        s_tdata        <= '0;
        s_tlast        <= 1'b0;
        carry_bits      = '0;
        carry_count     = '0;
        held_byte       = '0;
        byte_waiting    = 1'b0;
        text_stopped    = 1'b0;
        buffer_samples  = '0;
        mismatches      = 0;
        chars_accepted  = 0;
        no_gaps         = 1'b0;
        always_ready    = 1'b0;
        hold_request    = 1'b0;
        paused          = 1'b0;

        // directed table
        directed_rows = '{
            '{"A",        1'b1, 1'b1, EMPTY_END},  // lone sextet, no byte
            '{8'h00,      1'b1, 1'b1, EMPTY_END},  // lowest code, skipped
            '{8'hFF,      1'b1, 1'b1, EMPTY_END},  // highest code, skipped
            '{CH_EQUALS,  1'b1, 1'b1, EMPTY_END},  // stop char closing the buffer
            '{CH_SLASH,   1'b0, 1'b0, '0},
            '{CH_SLASH,   1'b0, 1'b0, '0},
            '{CH_SLASH,   1'b0, 1'b0, '0},         // sample 16'hFFFF
            '{CH_SLASH,   1'b1, 1'b1, ONE_END},    // odd trailing byte dropped
            '{"A",        1'b0, 1'b0, '0},
            '{"I",        1'b0, 1'b0, '0},
            '{8'h21,      1'b0, 1'b0, '0},         // skipped in mid text
            '{"A",        1'b0, 1'b0, '0},         // most negative sample
            '{CH_PLUS,    1'b0, 1'b0, '0},
            '{"9",        1'b0, 1'b0, '0},
            '{"a",        1'b0, 1'b0, '0},
            '{"z",        1'b0, 1'b0, '0},
            '{CH_CR,      1'b0, 1'b0, '0},         // carriage return stops decoding
            '{"Z",        1'b0, 1'b0, '0},         // ignored after the stop
            '{"Z",        1'b1, 1'b1, TWO_END},
            '{"Q",        1'b0, 1'b0, '0},
            '{"D",        1'b0, 1'b0, '0},
            '{CH_LF,      1'b0, 1'b0, '0},         // line feed stops, pending byte lost
            '{"B",        1'b1, 1'b1, EMPTY_END},
            '{CH_SPACE,   1'b0, 1'b0, '0},         // space stops too
            '{"g",        1'b1, 1'b1, EMPTY_END}
        };

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_char(directed_rows[i].ch, directed_rows[i].last,
                      directed_rows[i].typed, directed_rows[i].want);
        drain_results();

        // random buffers; the receiver holds off once early on while characters keep coming
        hold_request = 1'b1;
        start_count  = chars_accepted;
        while (chars_accepted - start_count < RANDOM_CHARS)
        begin
            send_random_buffer();
            if (!paused && chars_accepted - start_count >= RANDOM_CHARS / 2)
            begin
                paused = 1'b1;
                drain_results();
            end
        end
        drain_results();

        // one long buffer with no gaps on either side
        no_gaps      = 1'b1;
        always_ready = 1'b1;
        for (int q = 0; q < LONG_QUADS; q++)
            for (int k = 0; k < 4; k++)
                send_char(alphabet_char(6'($urandom_range(0, 63))),
                          (q == LONG_QUADS - 1) && (k == 3), 1'b0, '0);
        no_gaps      = 1'b0;
        always_ready = 1'b0;

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

@@ files.f @@
rtl/b64pcm_pkg.sv
rtl/b64pcm_core.sv
rtl/b64pcm_outreg.sv
rtl/base64_pcm16_sample_decoder_unit.sv
rtl/b64pcm_checker.sv
tb/tb.sv
